/* design/svfcc_pkg.sv */
// svfcc_pkg: shared types and constants of the stereo state-variable filter cascade
// transaction structs, command and register codes, fixed-point widths
// no dependencies
package svfcc_pkg;

    // fixed-point formats
    localparam int SMP_W     = 24;   // samples, Q1.23
    localparam int COEF_W    = 32;   // coefficients, Q6.26
    localparam int COEF_FRAC = 26;
    localparam int INTEG_W   = 40;   // integrator state
    localparam int GAIN_FRAC = 23;
    localparam int LEVEL_W   = 24;   // gains and envelopes, unsigned
    localparam int CFG_W     = 24;
    localparam int SPLIT     = 20;   // split point of a 40-bit operand into two partials

    // shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // commands
    localparam logic [2:0] CMD_SAMPLE = 3'd0;
    localparam logic [2:0] CMD_COEF   = 3'd1;
    localparam logic [2:0] CMD_ENABLE = 3'd2;
    localparam logic [2:0] CMD_GAIN   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_MONO    = 2'd0;
    localparam logic [1:0] CFG_RELEASE = 2'd1;
    localparam logic [1:0] CFG_GLIDE   = 2'd2;

    // coefficient words of one section
    localparam logic [2:0] W_A1 = 3'd0;
    localparam logic [2:0] W_A2 = 3'd1;
    localparam logic [2:0] W_A3 = 3'd2;
    localparam logic [2:0] W_M0 = 3'd3;
    localparam logic [2:0] W_M1 = 3'd4;
    localparam logic [2:0] W_M2 = 3'd5;
    localparam int NUM_WORDS = 6;

    localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;
    localparam logic [LEVEL_W-1:0]       GAIN_ONE = LEVEL_W'(1) << GAIN_FRAC;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [SMP_W-1:0]  left_in;
        logic signed [SMP_W-1:0]  right_in;
        logic                     bank_sel;
        logic [1:0]               section_sel;
        logic [2:0]               coef_index;
        logic signed [COEF_W-1:0] coef_value;
        logic                     enable_flag;
        logic [LEVEL_W-1:0]       gain_target;
    } t_in_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] left_out;
        logic signed [SMP_W-1:0] right_out;
        logic signed [SMP_W-1:0] key_left;
        logic signed [SMP_W-1:0] key_right;
        logic [LEVEL_W-1:0]      input_peak;
        logic [LEVEL_W-1:0]      output_peak;
    } t_out_item;

endpackage

/* design/svfcc_mul.sv */
// svfcc_mul: shared signed multiplier with a registered product
// depends on svfcc_pkg for operand widths
module svfcc_mul
    import svfcc_pkg::*;
(
    input  logic                       i_clk,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [MUL_P_W-1:0]  o_p
);

    // one product per cycle, product available in the next cycle
    always_ff @(posedge i_clk) begin
        o_p <= MUL_P_W'(i_a) * MUL_P_W'(i_b);
    end

endmodule

/* design/svf_cut_cascade_stereo_top.sv */
// svf_cut_cascade_stereo_top: stereo cascade of trapezoidal state-variable filter sections
// with gliding broadband gain, key cascade and peak envelopes
// depends on svfcc_pkg and svfcc_mul
//
// One transaction is taken at a time. Commands other than a sample finish in the cycle of
// acceptance. A sample runs P cascade passes (4 in stereo, 2 in mono) over C channels
// (2 stereo, 1 mono). Its duration is set by the single shared 33x25 multiplier, which
// does fourteen partial products for each section step, and by the registered reads of
// the coefficient and integrator memories. Coefficient and integrator stores need no
// clearing pass after reset: per-entry valid bits give their reset values.
module svf_cut_cascade_stereo_top
    import svfcc_pkg::*;
#(
    parameter int NUM_SECTIONS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    localparam int COEF_DEPTH = 2 * NUM_SECTIONS * NUM_WORDS;
    localparam int INT_DEPTH  = 8 * NUM_SECTIONS;
    localparam int EN_DEPTH   = 2 * NUM_SECTIONS;
    localparam int CA_W  = $clog2(COEF_DEPTH);
    localparam int IA_W  = $clog2(INT_DEPTH);
    localparam int EN_AW = (EN_DEPTH > 1) ? $clog2(EN_DEPTH) : 1;
    localparam int KW    = $clog2(NUM_SECTIONS + 1);

    localparam logic [3:0] ENV_LAST  = 4'd3;
    localparam logic [3:0] TICK_LAST = 4'd15;
    localparam logic [3:0] GAIN_LAST = 4'd1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ENV  = 6'b000010,
        S_SEC  = 6'b000100,
        S_TICK = 6'b001000,
        S_GAIN = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    // helpers
    function automatic logic signed [INTEG_W-1:0] sat_int(input logic signed [79:0] v);
        logic signed [79:0] hi_lim;
        logic signed [79:0] lo_lim;
        hi_lim = (80'sd1 <<< (INTEG_W - 1)) - 80'sd1;
        lo_lim = -(80'sd1 <<< (INTEG_W - 1));
        if (v > hi_lim) return hi_lim[INTEG_W-1:0];
        if (v < lo_lim) return lo_lim[INTEG_W-1:0];
        return v[INTEG_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [79:0] v);
        logic signed [79:0] hi_lim;
        logic signed [79:0] lo_lim;
        hi_lim = (80'sd1 <<< (SMP_W - 1)) - 80'sd1;
        lo_lim = -(80'sd1 <<< (SMP_W - 1));
        if (v > hi_lim) return hi_lim[SMP_W-1:0];
        if (v < lo_lim) return lo_lim[SMP_W-1:0];
        return v[SMP_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] abs_smp(input logic signed [SMP_W-1:0] v);
        return v[SMP_W-1] ? LEVEL_W'(~v + 1'b1) : LEVEL_W'(v);
    endfunction

    function automatic logic [IA_W-1:0] f_iaddr(input logic b, input logic ch,
                                                input int s, input logic w);
        return IA_W'(((int'(b) * 2 + int'(ch)) * NUM_SECTIONS + s) * 2 + int'(w));
    endfunction

    function automatic logic [CA_W-1:0] f_caddr(input logic b, input int s,
                                                input logic [2:0] w);
        return CA_W'((int'(b) * NUM_SECTIONS + s) * NUM_WORDS + int'(w));
    endfunction

    // coefficient word fetched in a section step, registered for use in the next step
    function automatic logic [2:0] f_word(input logic [3:0] c);
        case (c)
            4'd0, 4'd1:                 return W_A1;
            4'd2, 4'd3, 4'd4, 4'd5:     return W_A2;
            4'd6, 4'd7:                 return W_A3;
            4'd8, 4'd9:                 return W_M0;
            4'd10, 4'd11:               return W_M1;
            default:                    return W_M2;
        endcase
    endfunction

    t_state r_state, n_state;
    logic [3:0]          r_step;
    logic [1:0]          r_pass;
    logic [KW-1:0]       r_k;

    logic                r_mono;
    logic [CFG_W-1:0]    r_rel;
    logic [CFG_W-1:0]    r_glide;
    logic [EN_DEPTH-1:0] r_en;
    logic [INT_DEPTH-1:0]  r_int_vld;
    logic [COEF_DEPTH-1:0] r_coef_vld;
    logic [LEVEL_W-1:0]  r_cur_g, r_tgt_g, r_in_env, r_out_env, r_last_pk;
    logic                r_out_valid;
    t_out_item           r_out;

    logic signed [SMP_W-1:0]   r_xl, r_xr, r_x, r_yl, r_yr, r_kl;
    logic [LEVEL_W-1:0]        r_pk;
    logic signed [INTEG_W-1:0] r_iq1, r_iq2, r_v3, r_v1, r_v2;
    logic                      r_iv1, r_iv2;
    logic signed [INTEG_W+1:0] r_acc;
    logic signed [MUL_P_W-1:0] r_phi;
    logic signed [COEF_W-1:0]  r_cq;

    logic signed [COEF_W-1:0]  coef_mem [COEF_DEPTH];
    logic signed [INTEG_W-1:0] int_mem  [INT_DEPTH];

    logic                      w_in_acc, w_cfg_acc, w_sec_ok, w_at_end, w_done_ok;
    logic [EN_AW-1:0]          w_en_idx, w_cmd_en_idx;
    logic signed [INTEG_W-1:0] w_ic1, w_ic2, w_b, w_mr, w_ic1_new, w_ic2_new;
    logic signed [79:0]        w_full;
    logic signed [MUL_A_W-1:0] w_ma;
    logic signed [MUL_B_W-1:0] w_mb;
    logic signed [MUL_P_W-1:0] r_prod;
    logic [3:0]                w_cm1;
    logic [2:0]                w_j, w_cw;
    logic [CA_W-1:0]           w_ca, w_coef_wa;
    logic                      w_coef_we, w_int_we, w_int_re;
    logic [IA_W-1:0]           w_int_wa, w_int_ra1, w_int_ra2;
    logic signed [INTEG_W-1:0] w_int_wd;
    logic signed [SMP_W-1:0]   w_y_sec, w_y_gain, w_xr_in;
    logic [LEVEL_W-1:0]        w_env_dec, w_pk_in;
    logic signed [79:0]        w_glide_step;
    logic signed [LEVEL_W:0]   w_gerr;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_done_ok   = !r_out_valid || !i_out_stall;

    // command decode
    assign w_sec_ok     = int'(i_in_data.section_sel) < NUM_SECTIONS;
    assign w_cmd_en_idx = EN_AW'(int'(i_in_data.bank_sel) * NUM_SECTIONS
                                + int'(i_in_data.section_sel));
    assign w_coef_we    = w_in_acc && (i_in_data.cmd == CMD_COEF) && w_sec_ok
                          && (int'(i_in_data.coef_index) < NUM_WORDS);
    assign w_coef_wa    = f_caddr(i_in_data.bank_sel, int'(i_in_data.section_sel),
                                  i_in_data.coef_index);
    assign w_xr_in      = r_mono ? i_in_data.left_in : i_in_data.right_in;
    assign w_pk_in      = (!r_mono && abs_smp(i_in_data.right_in) > abs_smp(i_in_data.left_in))
                          ? abs_smp(i_in_data.right_in) : abs_smp(i_in_data.left_in);

    // section walk
    assign w_en_idx = EN_AW'(int'(r_pass[0]) * NUM_SECTIONS + int'(r_k));
    assign w_at_end = (r_k == KW'(NUM_SECTIONS));

    // integrator reads with reset value for unwritten entries
    assign w_ic1 = r_iv1 ? r_iq1 : '0;
    assign w_ic2 = r_iv2 ? r_iq2 : '0;

    // section step operand and rounded coefficient product
    assign w_cm1 = r_step - 4'd1;
    assign w_j   = w_cm1[3:1];
    always_comb begin
        case (w_j)
            3'd0, 3'd2: w_b = w_ic1;
            3'd1, 3'd3: w_b = r_v3;
            3'd4:       w_b = INTEG_W'(r_x);
            3'd5:       w_b = r_v1;
            3'd6:       w_b = r_v2;
            default:    w_b = '0;
        endcase
    end
    assign w_full = (80'(r_phi) <<< SPLIT) + 80'(r_prod) + (80'sd1 <<< (COEF_FRAC - 1));
    assign w_mr   = sat_int(w_full >>> COEF_FRAC);

    assign w_ic1_new = sat_int((80'(r_v1) <<< 1) - 80'(w_ic1));
    assign w_ic2_new = sat_int((80'(r_v2) <<< 1) - 80'(w_ic2));
    assign w_y_sec   = sat_smp(80'(r_acc) + 80'(w_mr));
    assign w_y_gain  = sat_smp((80'(r_prod) + (80'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC);
    assign w_env_dec = LEVEL_W'((80'(r_prod) + (80'sd1 <<< (LEVEL_W - 1))) >>> LEVEL_W);
    assign w_glide_step = (80'(r_prod) + (80'sd1 <<< (LEVEL_W - 1))) >>> LEVEL_W;
    assign w_gerr = $signed({1'b0, r_tgt_g}) - $signed({1'b0, r_cur_g});

    // multiplier operand selection
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_ENV: begin
                case (r_step)
                    4'd0: begin
                        w_ma = MUL_A_W'(r_in_env);
                        w_mb = MUL_B_W'(r_rel);
                    end
                    4'd1: begin
                        w_ma = MUL_A_W'(r_out_env);
                        w_mb = MUL_B_W'(r_rel);
                    end
                    4'd2: begin
                        w_ma = MUL_A_W'(w_gerr);
                        w_mb = MUL_B_W'(r_glide);
                    end
                    default: ;
                endcase
            end
            S_GAIN: begin
                w_ma = MUL_A_W'(r_x);
                w_mb = MUL_B_W'(r_cur_g);
            end
            S_TICK: begin
                if (r_step != 4'd0 && r_step != TICK_LAST) begin
                    w_ma = MUL_A_W'(r_cq);
                    if (r_step[0]) begin
                        w_mb = MUL_B_W'(w_b >>> SPLIT);
                    end else begin
                        w_mb = $signed(MUL_B_W'(w_b[SPLIT-1:0]));
                    end
                end
            end
            default: ;
        endcase
    end

    svfcc_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (r_prod)
    );

    // memory port control
    assign w_cw      = f_word(r_step);
    assign w_ca      = f_caddr(r_pass[0], int'(r_k), w_cw);
    assign w_int_re  = (r_state == S_TICK) && (r_step == 4'd0);
    assign w_int_ra1 = f_iaddr(r_pass[0], r_pass[1], int'(r_k), 1'b0);
    assign w_int_ra2 = f_iaddr(r_pass[0], r_pass[1], int'(r_k), 1'b1);
    assign w_int_we  = (r_state == S_TICK) && (r_step == 4'd6 || r_step == 4'd10);
    assign w_int_wa  = f_iaddr(r_pass[0], r_pass[1], int'(r_k), r_step == 4'd10);
    assign w_int_wd  = (r_step == 4'd10) ? w_ic2_new : w_ic1_new;

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (w_coef_we) begin
            coef_mem[w_coef_wa] <= i_in_data.coef_value;
        end
        if (r_coef_vld[w_ca]) begin
            r_cq <= coef_mem[w_ca];
        end else begin
            r_cq <= (w_cw == W_A1 || w_cw == W_M0) ? COEF_ONE : '0;
        end
    end

    // integrator memory
    always_ff @(posedge i_clk) begin
        if (w_int_we) begin
            int_mem[w_int_wa] <= w_int_wd;
        end
        if (w_int_re) begin
            r_iq1 <= int_mem[w_int_ra1];
            r_iq2 <= int_mem[w_int_ra2];
            r_iv1 <= r_int_vld[w_int_ra1];
            r_iv2 <= r_int_vld[w_int_ra2];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_in_acc && i_in_data.cmd == CMD_SAMPLE) n_state = S_ENV;
            S_ENV:  if (r_step == ENV_LAST) n_state = S_SEC;
            S_SEC: begin
                if (w_at_end) begin
                    if (!r_pass[0]) begin
                        n_state = S_GAIN;
                    end else if (r_pass[1] || r_mono) begin
                        n_state = S_FIN;
                    end
                end else if (r_en[w_en_idx]) begin
                    n_state = S_TICK;
                end
            end
            S_TICK: if (r_step == TICK_LAST) n_state = S_SEC;
            S_GAIN: if (r_step == GAIN_LAST) n_state = S_SEC;
            S_FIN:  if (w_done_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_pass      <= '0;
            r_k         <= '0;
            r_mono      <= 1'b0;
            r_rel       <= CFG_W'(16772556);
            r_glide     <= CFG_W'(564460);
            r_en        <= '0;
            r_int_vld   <= '0;
            r_coef_vld  <= '0;
            r_cur_g     <= GAIN_ONE;
            r_tgt_g     <= GAIN_ONE;
            r_in_env    <= '0;
            r_out_env   <= '0;
            r_last_pk   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? 4'd0 : r_step + 4'd1;

            // configuration writes
            if (w_cfg_acc) begin
                case (i_cfg_index)
                    CFG_MONO:    r_mono  <= i_cfg_data[0];
                    CFG_RELEASE: r_rel   <= i_cfg_data;
                    CFG_GLIDE:   r_glide <= i_cfg_data;
                    default: ;
                endcase
            end

            // commands other than a sample
            if (w_coef_we) begin
                r_coef_vld[w_coef_wa] <= 1'b1;
            end
            if (w_in_acc && i_in_data.cmd == CMD_ENABLE && w_sec_ok) begin
                if (i_in_data.enable_flag && !r_en[w_cmd_en_idx]) begin
                    for (int c = 0; c < 2; c++) begin
                        for (int w = 0; w < 2; w++) begin
                            r_int_vld[f_iaddr(i_in_data.bank_sel, 1'(c),
                                              int'(i_in_data.section_sel), 1'(w))] <= 1'b0;
                        end
                    end
                end
                r_en[w_cmd_en_idx] <= i_in_data.enable_flag;
            end
            if (w_in_acc && i_in_data.cmd == CMD_GAIN) begin
                r_tgt_g <= (i_in_data.gain_target > GAIN_ONE) ? GAIN_ONE
                                                               : i_in_data.gain_target;
            end
            if (w_in_acc && i_in_data.cmd == CMD_CLEAR) begin
                r_int_vld <= '0;
            end

            // integrator write-back marks the entry as written
            if (w_int_we) begin
                r_int_vld[w_int_wa] <= 1'b1;
            end

            // envelopes and gain glide
            if (r_state == S_ENV) begin
                case (r_step)
                    4'd1: r_in_env  <= (r_pk > r_in_env) ? r_pk : w_env_dec;
                    4'd2: r_out_env <= (r_last_pk > r_out_env) ? r_last_pk : w_env_dec;
                    4'd3: r_cur_g   <= LEVEL_W'(80'(r_cur_g) + w_glide_step);
                    default: ;
                endcase
                r_pass <= '0;
                r_k    <= '0;
            end

            // section walk and pass order
            if (r_state == S_SEC) begin
                if (w_at_end) begin
                    r_k <= '0;
                    if (r_pass == 2'd1 && !r_mono) begin
                        r_pass <= 2'd2;
                    end
                end else if (!r_en[w_en_idx]) begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (r_state == S_TICK && r_step == TICK_LAST) begin
                r_k <= r_k + 1'b1;
            end
            if (r_state == S_GAIN && r_step == GAIN_LAST) begin
                r_pass <= r_pass + 2'd1;
            end

            // result register
            if (r_state == S_FIN && w_done_ok) begin
                r_out_valid <= 1'b1;
                r_last_pk   <= (!r_mono && abs_smp(r_yr) > abs_smp(r_yl)) ? abs_smp(r_yr)
                                                                          : abs_smp(r_yl);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // sample capture
        if (w_in_acc && i_in_data.cmd == CMD_SAMPLE) begin
            r_xl <= i_in_data.left_in;
            r_xr <= w_xr_in;
            r_pk <= w_pk_in;
        end
        if (r_state == S_ENV && r_step == ENV_LAST) begin
            r_x <= r_xl;
        end

        // end of a key pass
        if (r_state == S_SEC && w_at_end && r_pass == 2'd1) begin
            r_kl <= r_x;
            r_x  <= r_xr;
        end

        // broadband gain
        if (r_state == S_GAIN && r_step == GAIN_LAST) begin
            r_x <= w_y_gain;
            if (r_pass[1]) begin
                r_yr <= w_y_gain;
            end else begin
                r_yl <= w_y_gain;
            end
        end

        // section step
        if (r_state == S_TICK) begin
            if (!r_step[0] && r_step != 4'd0) begin
                r_phi <= r_prod;
            end
            case (r_step)
                4'd1:  r_v3  <= sat_int(80'(r_x) - 80'(w_ic2));
                4'd3:  r_acc <= (INTEG_W+2)'(w_mr);
                4'd5:  r_v1  <= sat_int(80'(r_acc) + 80'(w_mr));
                4'd7:  r_acc <= (INTEG_W+2)'(w_ic2) + (INTEG_W+2)'(w_mr);
                4'd9:  r_v2  <= sat_int(80'(r_acc) + 80'(w_mr));
                4'd11: r_acc <= (INTEG_W+2)'(w_mr);
                4'd13: r_acc <= r_acc + (INTEG_W+2)'(w_mr);
                4'd15: r_x   <= w_y_sec;
                default: ;
            endcase
        end

        // result transaction
        if (r_state == S_FIN && w_done_ok) begin
            r_out.left_out    <= r_yl;
            r_out.right_out   <= r_mono ? r_yl : r_yr;
            r_out.key_left    <= r_kl;
            r_out.key_right   <= r_mono ? r_kl : r_x;
            r_out.input_peak  <= r_in_env;
            r_out.output_peak <= r_out_env;
        end
    end

`ifndef SYNTHESIS
    // coefficients never change under a running sample
    a_coef_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_coef_we |-> r_state == S_IDLE)
        else $error("coefficient write outside idle");

    // integrator write-back only for an enabled section
    a_int_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_int_we |-> r_en[w_en_idx])
        else $error("integrator write for disabled section");

    // finishing a sample loads the result register
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && w_done_ok) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished sample did not produce a result");

    // gliding gain never passes unity
    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_g <= GAIN_ONE && r_tgt_g <= GAIN_ONE)
        else $error("gain above unity");
`endif

endmodule
